>>> rtl/core/wbps_pkg.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan package
// Shared constants, configuration register codes and the pattern settings
// bundle that the top level hands to the comparison stage.
// ----------------------------------------------------------------------------
package wbps_pkg;

    // Pattern bytes the configuration registers can hold.
    localparam int CFG_BYTES        = 16;
    // Width of the pattern length register.
    localparam int LEN_W            = 5;
    // Configuration write channel.
    localparam int CFG_INDEX_W      = 8;
    localparam int CFG_DATA_W       = 64;
    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PATTERN  = 16;
    localparam int DEF_ADDRESS_BITS = 48;
    // Entries in the queue between the window stage and the compare stage.
    localparam int QUEUE_DEPTH      = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PATTERN_LOW  = 8'd0,
        CFG_PATTERN_HIGH = 8'd1,
        CFG_WILDCARD     = 8'd2,
        CFG_LENGTH       = 8'd3
    } t_cfg_reg;

    // Pattern settings as the compare stage sees them; len is already
    // clamped to the usable range.
    typedef struct packed {
        logic [CFG_BYTES*8-1:0] pattern;
        logic [CFG_BYTES-1:0]   wild;
        logic [LEN_W-1:0]       len;
    } t_pattern_cfg;

    // Length zero acts as one; anything above the window acts as the window.
    function automatic logic [LEN_W-1:0] clamp_length(input logic [LEN_W-1:0] raw,
                                                      input logic [LEN_W-1:0] limit);
        logic [LEN_W-1:0] len;
        len = raw;
        if (len == '0) begin
            len = LEN_W'(1);
        end
        if (len > limit) begin
            len = limit;
        end
        return len;
    endfunction

endpackage

>>> rtl/core/wildcard_byte_pattern_scan_core.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan core
// Streaming matcher that reports the start address of every run of bytes
// matching a pattern of up to sixteen bytes with per-byte wildcards.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one byte word per transfer: the byte and its
//   address in tdata, and in tuser a flag that marks the first byte of a
//   new region. Runs never straddle regions and overlapping hits are all
//   reported. The master stream carries one word per hit, holding the
//   address of the first byte of the matching run.
//   The configuration channel writes the pattern bytes, the wildcard mask
//   and the pattern length; it is always ready and must only be used while
//   no byte is in flight. Length zero acts as one, lengths above the window
//   act as the window.
//   A byte's hit reaches the master side through the queue and the output
//   register. While the receiver keeps up, one byte is taken every cycle:
//   the window stage pushes into a two-word queue, the compare stage drains
//   one word per cycle into the output register, so the sustained rate is
//   set by that register. When the receiver stalls, the output register
//   holds its word, the queue fills, and s_axis_tready falls once both
//   queue words are taken. Reset clears the byte count, the queue and the
//   output valid, sets the pattern registers to zero and the length to one.
// ----------------------------------------------------------------------------
module wildcard_byte_pattern_scan_core #(
    parameter int MAX_PATTERN  = wbps_pkg::DEF_MAX_PATTERN,
    parameter int ADDRESS_BITS = wbps_pkg::DEF_ADDRESS_BITS
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Byte stream in.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // data_byte, byte_address, zero fill to whole bytes.
    input  logic [((8+ADDRESS_BITS+7)/8)*8-1:0]    s_axis_tdata,
    // first_of_region.
    input  logic [0:0]                             s_axis_tuser,
    // Hit stream out.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // hit_address, zero fill to whole bytes.
    output logic [((ADDRESS_BITS+7)/8)*8-1:0]      m_axis_tdata,
    // Configuration writes.
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import wbps_pkg::*;

    // Only as many window bytes as the pattern registers can use are kept.
    localparam int WINDOW = (MAX_PATTERN < CFG_BYTES) ? MAX_PATTERN : CFG_BYTES;
    localparam int QW     = WINDOW * 8 + ADDRESS_BITS + 1;

    logic [63:0]          r_pattern_low;
    logic [63:0]          r_pattern_high;
    logic [CFG_BYTES-1:0] r_wildcard;
    logic [LEN_W-1:0]     r_length;
    t_pattern_cfg         pattern_cfg;

    logic                    push;
    logic [QW-1:0]           push_data;
    logic                    queue_ready;
    logic                    pop;
    logic                    queue_valid;
    logic [QW-1:0]           queue_data;
    logic [ADDRESS_BITS-1:0] hit_address;

    // Configuration registers; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_low  <= '0;
            r_pattern_high <= '0;
            r_wildcard     <= '0;
            r_length       <= LEN_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_PATTERN_LOW:  r_pattern_low  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_pattern_high <= i_cfg_data;
                CFG_WILDCARD:     r_wildcard     <= i_cfg_data[CFG_BYTES-1:0];
                CFG_LENGTH:       r_length       <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        pattern_cfg.pattern = {r_pattern_high, r_pattern_low};
        pattern_cfg.wild    = r_wildcard;
        pattern_cfg.len     = clamp_length(r_length, LEN_W'(WINDOW));
    end

    wbps_front #(
        .WINDOW       (WINDOW),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (s_axis_tvalid),
        .o_ready           (s_axis_tready),
        .i_data_byte       (s_axis_tdata[7:0]),
        .i_byte_address    (s_axis_tdata[8 +: ADDRESS_BITS]),
        .i_first_of_region (s_axis_tuser[0]),
        .i_len             (pattern_cfg.len),
        .o_push            (push),
        .o_push_data       (push_data),
        .i_queue_ready     (queue_ready)
    );

    wbps_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .o_ready     (queue_ready),
        .i_pop       (pop),
        .o_valid     (queue_valid),
        .o_data      (queue_data)
    );

    wbps_back #(
        .WINDOW       (WINDOW),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (pattern_cfg),
        .i_q_valid     (queue_valid),
        .i_q_data      (queue_data),
        .o_q_pop       (pop),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_hit_address (hit_address)
    );

    always_comb begin
        m_axis_tdata                   = '0;
        m_axis_tdata[ADDRESS_BITS-1:0] = hit_address;
    end

endmodule

>>> rtl/core/wbps_front.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan: window stage
// Accepts bytes, shifts them into the window of the current region, counts
// bytes since the region start and queues a snapshot for the compare stage.
// ----------------------------------------------------------------------------
module wbps_front #(
    parameter int WINDOW       = 16,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_data_byte,
    input  logic [ADDRESS_BITS-1:0]        i_byte_address,
    input  logic                           i_first_of_region,
    input  logic [wbps_pkg::LEN_W-1:0]     i_len,
    output logic                           o_push,
    output logic [WINDOW*8+ADDRESS_BITS:0] o_push_data,
    input  logic                           i_queue_ready
);
    import wbps_pkg::*;

    localparam int CW = $clog2(WINDOW + 1);

    logic [7:0]    r_window [WINDOW];
    logic [7:0]    n_window [WINDOW];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          enough;
    logic [WINDOW*8-1:0] window_flat;

    assign o_ready = i_queue_ready;
    assign o_push  = i_valid && i_queue_ready;

    // Bytes older than the region start are never compared because the
    // count limits the compare to bytes of this region, so the window needs
    // no clearing.
    always_comb begin
        n_window[0] = i_data_byte;
        for (int j = 1; j < WINDOW; j++) begin
            n_window[j] = r_window[j-1];
        end
        if (i_first_of_region) begin
            n_count = CW'(1);
        end else if (r_count == CW'(WINDOW)) begin
            n_count = r_count;
        end else begin
            n_count = r_count + CW'(1);
        end
        enough = (LEN_W'(n_count) >= i_len);
        for (int j = 0; j < WINDOW; j++) begin
            window_flat[j*8 +: 8] = n_window[j];
        end
    end

    assign o_push_data = {enough, i_byte_address, window_flat};

    always_ff @(posedge i_clk) begin
        if (o_push) begin
            for (int j = 0; j < WINDOW; j++) begin
                r_window[j] <= n_window[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_push) begin
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/wbps_queue.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan: snapshot queue
// A short first-in first-out queue between the window and compare stages.
// ----------------------------------------------------------------------------
module wbps_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_ready,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import wbps_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr;
    logic [PW-1:0]    r_rd_ptr;
    logic [NW-1:0]    r_fill;
    logic             do_push;
    logic             do_pop;

    assign o_ready = (r_fill != NW'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_fill <= r_fill + NW'(1);
            end else if (do_pop && !do_push) begin
                r_fill <= r_fill - NW'(1);
            end
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NW'(QUEUE_DEPTH))
        else $error("queue fill count beyond depth");

    a_fill_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_fill == $past(r_fill) + NW'(1)))
        else $error("queue fill did not grow on push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with differing pointers");

endmodule

>>> rtl/core/wbps_back.sv
// ----------------------------------------------------------------------------
// Wildcard byte pattern scan: compare stage
// Compares a queued window against the pattern and registers the start
// address of each hit in the output stage.
// ----------------------------------------------------------------------------
module wbps_back #(
    parameter int WINDOW       = 16,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wbps_pkg::t_pattern_cfg         i_cfg,
    input  logic                           i_q_valid,
    input  logic [WINDOW*8+ADDRESS_BITS:0] i_q_data,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [ADDRESS_BITS-1:0]        o_hit_address
);
    import wbps_pkg::*;

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    logic [7:0]              window [WINDOW];
    logic [ADDRESS_BITS-1:0] address;
    logic                    enough;
    logic [WINDOW-1:0]       pos_ok;
    logic [LEN_W-1:0]        idx;
    logic                    match;
    logic [ADDRESS_BITS-1:0] hit;

    logic                    r_valid;
    logic [ADDRESS_BITS-1:0] r_hit;

    // Pattern byte k lines up with window entry len-1-k (entry 0 is newest).
    always_comb begin
        for (int j = 0; j < WINDOW; j++) begin
            window[j] = i_q_data[j*8 +: 8];
        end
        address = i_q_data[WINDOW*8 +: ADDRESS_BITS];
        enough  = i_q_data[WINDOW*8+ADDRESS_BITS];
        idx     = '0;
        for (int k = 0; k < WINDOW; k++) begin
            idx = i_cfg.len - LEN_W'(1) - LEN_W'(k);
            pos_ok[k] = (LEN_W'(k) >= i_cfg.len) || i_cfg.wild[k]
                        || (window[idx[IW-1:0]] == i_cfg.pattern[k*8 +: 8]);
        end
        match = enough && (&pos_ok);
        hit   = address - ADDRESS_BITS'(i_cfg.len - LEN_W'(1));
    end

    assign o_q_pop       = i_q_valid && (!r_valid || i_ready);
    assign o_valid       = r_valid;
    assign o_hit_address = r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= match;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && match) begin
            r_hit <= hit;
        end
    end

endmodule
